// ===== src/tsss_pkg.sv =====
// tsss_pkg: shared constants, codes and types of the tick sleep slice scheduler
// no dependencies
`default_nettype none
package tsss_pkg;
  localparam int MAX_TASKS = 16;
  localparam int ID_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int TIME_W = 32;
  localparam int SLICE_W = 16;
  localparam int DELAY_W = 16;
  localparam int MODE_W = 3;
  localparam int ADDR_W = 3;
  localparam logic [CNT_W-1:0] NONE_ID = CNT_W'(MAX_TASKS);
  localparam logic [SLICE_W-1:0] SLICE_RESET = SLICE_W'(10);
  localparam logic [ADDR_W-1:0] REG_TIME_SLICE = '0;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK     = 3'd0,
    MODE_CREATE   = 3'd1,
    MODE_SLEEP    = 3'd2,
    MODE_DISPATCH = 3'd3,
    MODE_QUERY    = 3'd4
  } mode_e;

  typedef struct packed {
    logic            push;
    logic            pop;
    logic [ID_W-1:0] push_id;
  } fifo_ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [ID_W-1:0]  head_id;
  } fifo_sts_t;
endpackage
`default_nettype wire

// ===== src/tsss_if.sv =====
// tsss_in_if and tsss_out_if: valid/ready channels of the scheduler
// depends on tsss_pkg
`default_nettype none
interface tsss_in_if;
  logic                          valid;
  logic                          ready;
  logic [tsss_pkg::MODE_W-1:0]   mode;
  logic [tsss_pkg::DELAY_W-1:0]  sleep_ticks;
  modport source (output valid, output mode, output sleep_ticks, input ready);
  modport sink (input valid, input mode, input sleep_ticks, output ready);
endinterface

interface tsss_out_if;
  logic                          valid;
  logic                          ready;
  logic [tsss_pkg::CNT_W-1:0]    running_task;
  logic [tsss_pkg::ID_W-1:0]     created_task;
  logic                          create_failed;
  logic                          slice_expired;
  logic [tsss_pkg::CNT_W-1:0]    woken_count;
  logic [tsss_pkg::TIME_W-1:0]   current_time;
  modport source (output valid, output running_task, output created_task,
                  output create_failed, output slice_expired, output woken_count,
                  output current_time, input ready);
  modport sink (input valid, input running_task, input created_task,
                input create_failed, input slice_expired, input woken_count,
                input current_time, output ready);
endinterface
`default_nettype wire

// ===== src/tsss_fifo.sv =====
// tsss_fifo: circular id queue with simultaneous pop and push
// depends on tsss_pkg
`default_nettype none
module tsss_fifo (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  tsss_pkg::fifo_ctl_t  ctl_i,
  output tsss_pkg::fifo_sts_t  sts_o
);
  logic [tsss_pkg::ID_W-1:0]  mem_q [tsss_pkg::MAX_TASKS];
  logic [tsss_pkg::ID_W-1:0]  head_q, head_d;
  logic [tsss_pkg::CNT_W-1:0] count_q, count_d;
  logic [tsss_pkg::ID_W-1:0]  tail;
  logic                       do_pop, do_push;

  assign do_pop  = ctl_i.pop && (count_q != '0);
  assign do_push = ctl_i.push && ((count_q != tsss_pkg::NONE_ID) || do_pop);
  assign tail    = tsss_pkg::ID_W'((tsss_pkg::CNT_W'(head_q) + count_q)
                   % tsss_pkg::MAX_TASKS);

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (do_pop) begin
      head_d  = tsss_pkg::ID_W'((tsss_pkg::CNT_W'(head_q) + 1'b1) % tsss_pkg::MAX_TASKS);
      count_d = count_d - 1'b1;
    end
    if (do_push) begin
      count_d = count_d + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[tail] <= ctl_i.push_id;
    end
  end

  assign sts_o.count   = count_q;
  assign sts_o.head_id = mem_q[head_q];
`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= tsss_pkg::NONE_ID) else $error("fifo count out of range");
  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.push && !ctl_i.pop && count_q != tsss_pkg::NONE_ID) |=>
    count_q == $past(count_q) + 1'b1) else $error("push lost");
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.pop && !ctl_i.push && count_q == '0) |=> count_q == '0)
    else $error("pop of empty queue");
`endif
endmodule
`default_nettype wire

// ===== src/tick_sleep_slice_scheduler.sv =====
// tick_sleep_slice_scheduler: round robin task scheduler with a sleep queue
// depends on tsss_pkg, tsss_if and tsss_fifo
// create, sleep, dispatch and query words pass from acceptance through the
// finish and output states to the result register; a tick first walks the
// sleep queue, one entry per read and compare state pair, through the single
// wake time memory read port and one 32 bit compare. one word is in work at a
// time; the result register frees the input side once it is loaded
`default_nettype none
module tick_sleep_slice_scheduler (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  tsss_in_if.sink                         in_i,
  tsss_out_if.source                      out_o,
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire [tsss_pkg::ADDR_W-1:0]      paddr,
  input  wire [31:0]                      pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_FINISH, S_OUT} state_e;

  state_e                          state_q, state_d;
  logic [tsss_pkg::TIME_W-1:0]     time_q, time_d;
  logic [tsss_pkg::CNT_W-1:0]      run_q, run_d;
  logic [tsss_pkg::SLICE_W-1:0]    slice_q, slice_d, tslice_q;
  logic [tsss_pkg::CNT_W-1:0]      next_free_q, next_free_d;
  logic [tsss_pkg::CNT_W-1:0]      left_q, left_d, woken_q, woken_d;
  logic [tsss_pkg::ID_W-1:0]       created_q, created_d, scan_id_q;
  logic                            failed_q, failed_d, expired_q, expired_d;
  logic                            tick_q, tick_d;
  logic [tsss_pkg::TIME_W-1:0]     wake_mem [tsss_pkg::MAX_TASKS];
  logic [tsss_pkg::TIME_W-1:0]     wt_q;
  logic                            we;
  logic [tsss_pkg::ID_W-1:0]       waddr;
  logic [tsss_pkg::TIME_W-1:0]     wdata;
  tsss_pkg::fifo_ctl_t             rdy_ctl, slp_ctl;
  tsss_pkg::fifo_sts_t             rdy_sts, slp_sts;
  logic                            accept, user_run, out_load;
  logic                            ov_q;
  logic [tsss_pkg::CNT_W-1:0]      o_run_q, o_woken_q;
  logic [tsss_pkg::ID_W-1:0]       o_created_q;
  logic                            o_failed_q, o_expired_q;
  logic [tsss_pkg::TIME_W-1:0]     o_time_q;

  tsss_fifo u_ready (.clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(rdy_ctl), .sts_o(rdy_sts));
  tsss_fifo u_sleep (.clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(slp_ctl), .sts_o(slp_sts));

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign user_run   = (run_q != tsss_pkg::NONE_ID) && (run_q != '0);
  assign out_load   = (state_q == S_OUT) && (!ov_q || out_o.ready);

  always_comb begin
    state_d     = state_q;
    time_d      = time_q;
    run_d       = run_q;
    slice_d     = slice_q;
    next_free_d = next_free_q;
    left_d      = left_q;
    woken_d     = woken_q;
    created_d   = created_q;
    failed_d    = failed_q;
    expired_d   = expired_q;
    tick_d      = tick_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    rdy_ctl     = '0;
    slp_ctl     = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          woken_d   = '0;
          created_d = '0;
          failed_d  = 1'b0;
          expired_d = 1'b0;
          tick_d    = 1'b0;
          state_d   = S_FINISH;
          case (tsss_pkg::mode_e'(in_i.mode))
            tsss_pkg::MODE_TICK: begin
              tick_d = 1'b1;
              time_d = time_q + 1'b1;
              if (run_q != tsss_pkg::NONE_ID) begin
                slice_d = slice_q + 1'b1;
              end
              left_d = slp_sts.count;
              if (slp_sts.count != '0) begin
                state_d = S_SCAN_RD;
              end
            end
            tsss_pkg::MODE_CREATE: begin
              if (next_free_q == tsss_pkg::NONE_ID) begin
                failed_d = 1'b1;
              end else begin
                created_d       = next_free_q[tsss_pkg::ID_W-1:0];
                we              = 1'b1;
                waddr           = next_free_q[tsss_pkg::ID_W-1:0];
                rdy_ctl.push    = (next_free_q != '0);
                rdy_ctl.push_id = next_free_q[tsss_pkg::ID_W-1:0];
                next_free_d     = next_free_q + 1'b1;
              end
            end
            tsss_pkg::MODE_SLEEP: begin
              if (user_run) begin
                we              = 1'b1;
                waddr           = run_q[tsss_pkg::ID_W-1:0];
                wdata           = time_q + tsss_pkg::TIME_W'(in_i.sleep_ticks);
                slp_ctl.push    = 1'b1;
                slp_ctl.push_id = run_q[tsss_pkg::ID_W-1:0];
                run_d           = tsss_pkg::NONE_ID;
              end
            end
            tsss_pkg::MODE_DISPATCH: begin
              if (!user_run) begin
                if (rdy_sts.count != '0) begin
                  rdy_ctl.pop = 1'b1;
                  run_d       = tsss_pkg::CNT_W'(rdy_sts.head_id);
                  slice_d     = '0;
                end else if (run_q == tsss_pkg::NONE_ID && next_free_q != '0) begin
                  run_d   = '0;
                  slice_d = '0;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        slp_ctl.pop = 1'b1;
        state_d     = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (wt_q <= time_q) begin
          rdy_ctl.push    = 1'b1;
          rdy_ctl.push_id = scan_id_q;
          woken_d         = woken_q + 1'b1;
        end else begin
          slp_ctl.push    = 1'b1;
          slp_ctl.push_id = scan_id_q;
        end
        left_d  = left_q - 1'b1;
        state_d = (left_q == 1'b1) ? S_FINISH : S_SCAN_RD;
      end
      S_FINISH: begin
        if (tick_q && user_run && slice_q >= tslice_q) begin
          rdy_ctl.push    = 1'b1;
          rdy_ctl.push_id = run_q[tsss_pkg::ID_W-1:0];
          run_d           = tsss_pkg::NONE_ID;
          expired_d       = 1'b1;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      time_q      <= '0;
      run_q       <= tsss_pkg::NONE_ID;
      slice_q     <= '0;
      next_free_q <= '0;
      left_q      <= '0;
      woken_q     <= '0;
      created_q   <= '0;
      failed_q    <= 1'b0;
      expired_q   <= 1'b0;
      tick_q      <= 1'b0;
      tslice_q    <= tsss_pkg::SLICE_RESET;
      ov_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      time_q      <= time_d;
      run_q       <= run_d;
      slice_q     <= slice_d;
      next_free_q <= next_free_d;
      left_q      <= left_d;
      woken_q     <= woken_d;
      created_q   <= created_d;
      failed_q    <= failed_d;
      expired_q   <= expired_d;
      tick_q      <= tick_d;
      if (psel && penable && pwrite && paddr == tsss_pkg::REG_TIME_SLICE) begin
        tslice_q <= pwdata[tsss_pkg::SLICE_W-1:0];
      end
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      wake_mem[waddr] <= wdata;
    end
    if (state_q == S_SCAN_RD) begin
      wt_q      <= wake_mem[slp_sts.head_id];
      scan_id_q <= slp_sts.head_id;
    end
    if (out_load) begin
      o_run_q     <= run_q;
      o_woken_q   <= woken_q;
      o_created_q <= created_q;
      o_failed_q  <= failed_q;
      o_expired_q <= expired_q;
      o_time_q    <= time_q;
    end
  end

  assign out_o.valid         = ov_q;
  assign out_o.running_task  = o_run_q;
  assign out_o.created_task  = o_created_q;
  assign out_o.create_failed = o_failed_q;
  assign out_o.slice_expired = o_expired_q;
  assign out_o.woken_count   = o_woken_q;
  assign out_o.current_time  = o_time_q;

  assign pready = 1'b1;
  assign prdata = (paddr == tsss_pkg::REG_TIME_SLICE) ? 32'(tslice_q) : '0;
`ifndef SYNTHESIS
  a_run_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q <= tsss_pkg::NONE_ID) else $error("running id out of range");
  a_task_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (rdy_sts.count + slp_sts.count + tsss_pkg::CNT_W'(user_run)
    + tsss_pkg::CNT_W'(next_free_q != '0) == next_free_q))
    else $error("task lost or duplicated");
  a_expired_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && o_expired_q) |-> (o_run_q == tsss_pkg::NONE_ID))
    else $error("preempted task still running");
`endif
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for tick_sleep_slice_scheduler, directed then random words
// depends on tsss_pkg, tsss_if and the scheduler rtl
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 3_000_000;

  typedef struct packed {
    logic [tsss_pkg::CNT_W-1:0]  running_task;
    logic [tsss_pkg::ID_W-1:0]   created_task;
    logic                        create_failed;
    logic                        slice_expired;
    logic [tsss_pkg::CNT_W-1:0]  woken_count;
    logic [tsss_pkg::TIME_W-1:0] current_time;
  } sched_word_t;

  typedef enum logic [1:0] {T_FREE, T_READY, T_RUN, T_SLEEP} task_st_e;

  class sched_scoreboard;
    logic [tsss_pkg::SLICE_W-1:0] slice_len;
    logic [tsss_pkg::TIME_W-1:0]  now;
    logic [tsss_pkg::CNT_W-1:0]   cur;
    logic [tsss_pkg::SLICE_W-1:0] slice_cnt[tsss_pkg::MAX_TASKS];
    logic [tsss_pkg::TIME_W-1:0]  life_cnt[tsss_pkg::MAX_TASKS];
    logic [tsss_pkg::TIME_W-1:0]  wake_at[tsss_pkg::MAX_TASKS];
    task_st_e                     tstate[tsss_pkg::MAX_TASKS];
    int                           free_q[$];
    int                           ready_q[$];
    int                           sleep_q[$];
    sched_word_t                  pending[$];
    int                           mismatches, checked, ticks, wakes, expiries, fails;

    function new();
      slice_len = tsss_pkg::SLICE_RESET;
      now = '0;
      cur = tsss_pkg::NONE_ID;
      for (int i = 0; i < tsss_pkg::MAX_TASKS; i++) begin
        slice_cnt[i] = '0;
        life_cnt[i] = '0;
        wake_at[i] = '0;
        tstate[i] = T_FREE;
        free_q.push_back(i);
      end
    endfunction

    function void note_word(logic [tsss_pkg::MODE_W-1:0] mode,
                            logic [tsss_pkg::DELAY_W-1:0] delay);
      sched_word_t e;
      int n, id;
      e = '0;
      case (mode)
        tsss_pkg::MODE_TICK: begin
          ticks++;
          if (cur != tsss_pkg::NONE_ID) begin
            slice_cnt[cur] = slice_cnt[cur] + 1'b1;
            life_cnt[cur] = life_cnt[cur] + 1;
          end
          now = now + 1;
          n = sleep_q.size();
          for (int i = 0; i < n; i++) begin
            id = sleep_q.pop_front();
            if (wake_at[id] <= now) begin
              tstate[id] = T_READY;
              ready_q.push_back(id);
              e.woken_count = e.woken_count + 1'b1;
            end else begin
              sleep_q.push_back(id);
            end
          end
          wakes += e.woken_count;
          if (cur != tsss_pkg::NONE_ID && cur != 0 && slice_cnt[cur] >= slice_len) begin
            tstate[cur] = T_READY;
            ready_q.push_back(cur);
            cur = tsss_pkg::NONE_ID;
            e.slice_expired = 1'b1;
            expiries++;
          end
        end
        tsss_pkg::MODE_CREATE: begin
          if (free_q.size() == 0) begin
            e.create_failed = 1'b1;
            fails++;
          end else begin
            id = free_q.pop_front();
            slice_cnt[id] = '0;
            life_cnt[id] = '0;
            wake_at[id] = '0;
            tstate[id] = T_READY;
            if (id > 0) ready_q.push_back(id);
            e.created_task = tsss_pkg::ID_W'(id);
          end
        end
        tsss_pkg::MODE_SLEEP: begin
          if (cur != tsss_pkg::NONE_ID && cur != 0) begin
            wake_at[cur] = now + delay;
            tstate[cur] = T_SLEEP;
            sleep_q.push_back(cur);
            cur = tsss_pkg::NONE_ID;
          end
        end
        tsss_pkg::MODE_DISPATCH: begin
          if (cur == tsss_pkg::NONE_ID || cur == 0) begin
            if (ready_q.size() > 0) begin
              if (cur == 0) tstate[0] = T_READY;
              id = ready_q.pop_front();
              cur = tsss_pkg::CNT_W'(id);
              slice_cnt[id] = '0;
              tstate[id] = T_RUN;
            end else if (cur == tsss_pkg::NONE_ID && tstate[0] != T_FREE) begin
              cur = '0;
              slice_cnt[0] = '0;
              tstate[0] = T_RUN;
            end
          end
        end
        default: ;
      endcase
      e.running_task = cur;
      e.current_time = now;
      pending.push_back(e);
    endfunction

    function void check_word(sched_word_t got);
      sched_word_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on word %0d: expected %p, got %p", checked, e, got);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [tsss_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  longint cycles;
  bit calm;

  tsss_in_if  inb();
  tsss_out_if outb();
  sched_scoreboard sb;

  tick_sleep_slice_scheduler uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(inb.sink), .out_o(outb.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 35) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  initial begin
    int g;
    outb.ready = 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      g = pick_gap();
      if (g > 0) begin
        outb.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      outb.ready <= 1'b1;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && outb.valid && outb.ready)
      sb.check_word({outb.running_task, outb.created_task, outb.create_failed,
                     outb.slice_expired, outb.woken_count, outb.current_time});
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_word(logic [tsss_pkg::MODE_W-1:0] mode,
                           logic [tsss_pkg::DELAY_W-1:0] delay);
    int g;
    g = pick_gap();
    if (g > 0) begin
      inb.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    inb.valid <= 1'b1;
    inb.mode <= mode;
    inb.sleep_ticks <= delay;
    @(posedge clk_i);
    while (!inb.ready) @(posedge clk_i);
    sb.note_word(mode, delay);
  endtask

  task automatic write_slice(logic [tsss_pkg::SLICE_W-1:0] v);
    inb.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= tsss_pkg::REG_TIME_SLICE;
    pwdata <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.slice_len = v;
  endtask

  function automatic logic [tsss_pkg::DELAY_W-1:0] pick_delay();
    int r;
    r = $urandom_range(99);
    if (r < 70) return tsss_pkg::DELAY_W'($urandom_range(30));
    if (r < 90) return tsss_pkg::DELAY_W'($urandom_range(300));
    return tsss_pkg::DELAY_W'($urandom_range(65535));
  endfunction

  function automatic logic [tsss_pkg::DELAY_W-1:0] any_delay();
    return tsss_pkg::DELAY_W'($urandom_range(65535));
  endfunction

  task automatic random_words(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45) send_word(tsss_pkg::MODE_TICK, any_delay());
      else if (r < 70) send_word(tsss_pkg::MODE_DISPATCH, any_delay());
      else if (r < 85) send_word(tsss_pkg::MODE_SLEEP, pick_delay());
      else if (r < 90) send_word(tsss_pkg::MODE_CREATE, any_delay());
      else send_word(tsss_pkg::MODE_W'($urandom_range(7, tsss_pkg::MODE_QUERY)),
                     any_delay());
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    rst_ni = 1'b0;
    inb.valid = 1'b0;
    inb.mode = tsss_pkg::MODE_QUERY;
    inb.sleep_ticks = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed opening at the reset slice length
    send_word(tsss_pkg::MODE_QUERY, '0);
    send_word(tsss_pkg::MODE_TICK, 16'hffff);
    send_word(tsss_pkg::MODE_DISPATCH, '0);
    send_word(tsss_pkg::MODE_CREATE, '0);
    send_word(tsss_pkg::MODE_DISPATCH, '0);
    send_word(tsss_pkg::MODE_SLEEP, 16'd5);
    send_word(tsss_pkg::MODE_TICK, '0);
    for (int i = 0; i < 3; i++) send_word(tsss_pkg::MODE_CREATE, '0);
    send_word(tsss_pkg::MODE_DISPATCH, '0);
    send_word(tsss_pkg::MODE_DISPATCH, '0);
    send_word(tsss_pkg::MODE_SLEEP, '0);
    send_word(tsss_pkg::MODE_TICK, '0);
    send_word(tsss_pkg::MODE_DISPATCH, '0);
    send_word(tsss_pkg::MODE_SLEEP, 16'hffff);
    for (int k = 1; k <= 3; k++)
      send_word(tsss_pkg::MODE_W'(tsss_pkg::MODE_QUERY + k), 16'hffff);
    send_word(tsss_pkg::MODE_DISPATCH, '0);
    for (int i = 0; i < 5; i++) send_word(tsss_pkg::MODE_TICK, '0);

    random_words(300);
    write_slice(16'd1);
    random_words(300);
    calm = 1'b1;
    write_slice(16'hffff);
    random_words(250);
    calm = 1'b0;
    write_slice(tsss_pkg::SLICE_W'($urandom_range(40, 2)));
    random_words(250);
    write_slice(16'd3);
    random_words(250);

    inb.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("%0d words checked: %0d ticks, %0d wakes, %0d slice expiries, %0d failed creates",
             sb.checked, sb.ticks, sb.wakes, sb.expiries, sb.fails);
    $display("slice lengths 10, 1, 65535, a random one and 3; %0d mismatches", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
